// ===== rtl/mask_line_of_sight_tester_core_macros.svh =====
// assertion macros for the line-of-sight tester rtl
// no dependencies; included by modules that carry assertions
`ifndef MASK_LINE_OF_SIGHT_TESTER_CORE_MACROS_SVH
`define MASK_LINE_OF_SIGHT_TESTER_CORE_MACROS_SVH
`ifndef SYNTH
`define MLOS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MLOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MLOS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MLOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/mlos_pkg.sv =====
// types, constants and command/status structs for the line-of-sight tester
// no dependencies
`default_nettype none
package mlos_pkg;
	localparam int MASK_WIDTH  = 320;
	localparam int MASK_HEIGHT = 200;
	localparam int PAGE_SPLIT  = 320;
	localparam int PAGE_PIXELS = MASK_WIDTH * MASK_HEIGHT;
	localparam int PIX_W   = $clog2(PAGE_PIXELS);
	localparam int FILL_W  = $clog2(PAGE_PIXELS + 1);
	localparam int CMP_W   = (FILL_W > 16) ? FILL_W : 16;
	localparam int X_W     = $clog2(MASK_WIDTH);
	localparam int Y_W     = $clog2(MASK_HEIGHT);
	localparam int POS_W   = 25;
	localparam int COORD_W = POS_W - 1 - 6;
	localparam int D_W     = 17;
	localparam int N_W     = 15;
	localparam int Q_W     = 7;
	localparam int DIV_STEPS = 7;
	localparam int IN_DATA_W  = 88;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [1:0] {
		OP_BEGIN  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_UNLOAD = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_WRITE, ST_DIV, ST_SETUP,
		ST_SMP_A, ST_SMP_B, ST_SMP_C, ST_SMP_D, ST_RESULT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic begin_pg;
		logic unload;
		logic wr_init;
		logic wr_px;
		logic div_init;
		logic div_step;
		logic setup;
		logic smp_a;
		logic smp_b;
		logic smp_c;
		logic advance;
		logic res_capture;
		logic res_bit;
		logic set_res;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic wr_done;
		logic div_done;
		logic smp_blk;
		logic n_last;
		logic out_free;
	} status_t;
endpackage
`default_nettype wire

// ===== rtl/mlos_ctrl.sv =====
// controller state machine for the line-of-sight tester
// depends on mlos_pkg and the assertion macro header
`default_nettype none
`include "mask_line_of_sight_tester_core_macros.svh"
module mlos_ctrl
	import mlos_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_fire,
	input  wire status_t status,
	output cmd_t         cmd
);
	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_fire) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (status.op)
					OP_BEGIN: begin
						cmd.begin_pg = 1'b1;
						state_d = ST_IDLE;
					end
					OP_UNLOAD: begin
						cmd.unload = 1'b1;
						state_d = ST_IDLE;
					end
					OP_APPEND: begin
						cmd.wr_init = 1'b1;
						state_d = ST_WRITE;
					end
					OP_QUERY: begin
						cmd.div_init = 1'b1;
						state_d = ST_DIV;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_WRITE: begin
				if (status.wr_done) state_d = ST_IDLE;
				else cmd.wr_px = 1'b1;
			end
			ST_DIV: begin
				if (status.div_done) state_d = ST_SETUP;
				else cmd.div_step = 1'b1;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d = ST_SMP_A;
			end
			ST_SMP_A: begin
				cmd.smp_a = 1'b1;
				state_d = ST_SMP_B;
			end
			ST_SMP_B: begin
				cmd.smp_b = 1'b1;
				state_d = ST_SMP_C;
			end
			ST_SMP_C: begin
				cmd.smp_c = 1'b1;
				state_d = ST_SMP_D;
			end
			ST_SMP_D: begin
				if (status.smp_blk) begin
					cmd.res_capture = 1'b1;
					cmd.res_bit = 1'b1;
					state_d = ST_RESULT;
				end else if (status.n_last) begin
					cmd.res_capture = 1'b1;
					state_d = ST_RESULT;
				end else begin
					cmd.advance = 1'b1;
					state_d = ST_SMP_A;
				end
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.set_res = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`MLOS_ASSERT_IMPL(a_res_free, clk, arst_n, cmd.set_res, status.out_free, "result pushed into a full output register")
	`MLOS_ASSERT_IMPL(a_wr_len, clk, arst_n, cmd.wr_px, !status.wr_done, "pixel write with no run length left")
	`MLOS_ASSERT_NEXT(a_march, clk, arst_n, state_q == ST_SMP_D && !status.smp_blk && !status.n_last, state_q == ST_SMP_A, "march stopped early")
endmodule
`default_nettype wire

// ===== rtl/mlos_dpath.sv =====
// datapath: mask memory, fill counts, divider, line march and output register
// depends on mlos_pkg
`default_nettype none
module mlos_dpath
	import mlos_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output status_t                    status,
	input  wire logic                  s_tvalid,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [IN_USER_W-1:0]  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);
	localparam logic [COORD_W-1:0] C_H     = COORD_W'(MASK_HEIGHT);
	localparam logic [COORD_W-1:0] C_W     = COORD_W'(MASK_WIDTH);
	localparam logic [COORD_W-1:0] C_SPLIT = COORD_W'(PAGE_SPLIT);
	localparam logic [FILL_W-1:0]  C_PIX   = FILL_W'(PAGE_PIXELS);

	// captured item
	op_t         op_q;
	logic        pg_q;
	logic [15:0] len_in_q;
	logic        val_q;
	logic [15:0] tx_q, ty_q, sx_q, sy_q;

	always_ff @(posedge clk) begin
		if (cmd.in_ready && s_tvalid) begin
			op_q     <= op_t'(s_tuser[1:0]);
			pg_q     <= s_tuser[2];
			len_in_q <= s_tdata[15:0];
			val_q    <= |s_tdata[23:16];
			tx_q     <= s_tdata[39:24];
			ty_q     <= s_tdata[55:40];
			sx_q     <= s_tdata[71:56];
			sy_q     <= s_tdata[87:72];
		end
	end

	// page state and run fill
	logic [FILL_W-1:0] fill_q [2];
	logic [1:0]        present_q;
	logic [15:0]       len_q;
	logic [FILL_W-1:0] room;
	logic [CMP_W-1:0]  clip;

	assign room = (fill_q[pg_q] >= C_PIX) ? '0 : C_PIX - fill_q[pg_q];
	assign clip = (CMP_W'(len_in_q) > CMP_W'(room)) ? CMP_W'(room) : CMP_W'(len_in_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
			present_q <= '0;
		end else if (cmd.unload) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
			present_q <= '0;
		end else if (cmd.begin_pg) begin
			fill_q[pg_q]    <= '0;
			present_q[pg_q] <= 1'b1;
		end else if (cmd.wr_px) begin
			fill_q[pg_q] <= fill_q[pg_q] + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_init) len_q <= clip[15:0];
		else if (cmd.wr_px) len_q <= len_q - 1'b1;
	end

	// mask memory, one bit per pixel, page in the top address bit
	logic mem [0:2**(PIX_W+1)-1];
	logic [PIX_W-1:0] idx_s2;
	logic             pg_s2;
	logic             rd_s3;

	always_ff @(posedge clk) begin
		if (cmd.wr_px) mem[{pg_q, fill_q[pg_q][PIX_W-1:0]}] <= val_q;
		if (cmd.smp_c) rd_s3 <= mem[{pg_s2, idx_s2}];
	end

	// deltas, major axis and minor-step divider
	logic signed [D_W-1:0] dx, dy;
	logic [D_W-1:0]        adx, ady, major_c;
	logic                  y_major;
	logic [D_W-1:0]        major_q;
	logic [D_W:0]          rem_q, trial;
	logic [Q_W-1:0]        q_q;
	logic [2:0]            cnt_q;
	logic                  minor_neg_q, maj_neg_q, y_major_q;
	logic [N_W-1:0]        n_q;

	always_comb begin
		dx = D_W'($signed(tx_q)) - D_W'($signed(sx_q));
		dy = D_W'($signed(ty_q)) - D_W'($signed(sy_q));
		if (dx == '0) dx = D_W'(1);
		if (dy == '0) dy = D_W'(1);
		adx = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
		ady = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
		y_major = ady > adx;
		major_c = y_major ? ady : adx;
	end

	assign trial = (cnt_q == '0) ? rem_q : {rem_q[D_W-1:0], 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			major_q     <= major_c;
			rem_q       <= {1'b0, (y_major ? adx : ady)};
			q_q         <= '0;
			cnt_q       <= '0;
			y_major_q   <= y_major;
			minor_neg_q <= y_major ? dx[D_W-1] : dy[D_W-1];
			maj_neg_q   <= y_major ? dy[D_W-1] : dx[D_W-1];
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, major_q}) begin
				rem_q <= trial - {1'b0, major_q};
				q_q   <= {q_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[Q_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// march position and steps
	logic signed [POS_W-1:0] fx_q, fy_q, stx_q, sty_q, st_min, st_maj;

	assign st_min = minor_neg_q ? -POS_W'({q_q, 2'b00}) : POS_W'({q_q, 2'b00});
	assign st_maj = maj_neg_q ? -POS_W'(256) : POS_W'(256);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			fx_q  <= {{(POS_W-22){sx_q[15]}}, sx_q, 6'b0};
			fy_q  <= {{(POS_W-22){sy_q[15]}}, sy_q, 6'b0};
			stx_q <= y_major_q ? st_min : st_maj;
			sty_q <= y_major_q ? st_maj : st_min;
			n_q   <= N_W'(major_q[D_W-1:2]) + 1'b1;
		end else if (cmd.advance) begin
			fx_q <= fx_q + stx_q;
			fy_q <= fy_q + sty_q;
			n_q  <= n_q - 1'b1;
		end
	end

	// sample stage a: bounds and page select
	logic [COORD_W-1:0] xc, yc, xr;
	logic               pg1;
	logic [X_W-1:0]     x_s1;
	logic [Y_W-1:0]     y_s1;
	logic               pg_s1, oob_s1, oob_s2, blk_s3;

	assign xc  = fx_q[POS_W-2:6];
	assign yc  = fy_q[POS_W-2:6];
	assign pg1 = xc > C_SPLIT;
	assign xr  = pg1 ? xc - C_SPLIT : xc;

	always_ff @(posedge clk) begin
		if (cmd.smp_a) begin
			x_s1   <= xr[X_W-1:0];
			y_s1   <= yc[Y_W-1:0];
			pg_s1  <= pg1;
			oob_s1 <= fx_q[POS_W-1] | fy_q[POS_W-1] | (yc >= C_H) | (xr >= C_W)
				| !present_q[pg1];
		end
		// stage b: pixel index
		if (cmd.smp_b) begin
			idx_s2 <= PIX_W'(PIX_W'(y_s1) * PIX_W'(MASK_WIDTH)) + PIX_W'(x_s1);
			pg_s2  <= pg_s1;
			oob_s2 <= oob_s1;
		end
		// stage c: fill check alongside the memory read
		if (cmd.smp_c) begin
			blk_s3 <= oob_s2 | (FILL_W'(idx_s2) >= fill_q[pg_s2]);
		end
	end

	// result and output register
	logic res_q;
	always_ff @(posedge clk) begin
		if (cmd.res_capture) res_q <= cmd.res_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.set_res) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_res) m_tdata <= {{(OUT_DATA_W-1){1'b0}}, res_q};
	end

	// status back to the controller
	always_comb begin
		status.op       = op_q;
		status.wr_done  = len_q == '0;
		status.div_done = cnt_q == 3'(DIV_STEPS);
		status.smp_blk  = blk_s3 | rd_s3;
		status.n_last   = n_q == N_W'(1);
		status.out_free = !m_tvalid || m_tready;
	end
endmodule
`default_nettype wire

// ===== rtl/mask_line_of_sight_tester_core.sv =====
// top level of the line-of-sight tester: controller plus datapath
// depends on mlos_pkg, mlos_ctrl and mlos_dpath
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser {page, op}, tdata run and line fields
// m_*      out  m_tvalid/m_tready  tdata line_blocked
//
// items are taken one at a time; the decode state follows acceptance in the next cycle
// begin and unload finish in decode; a run writes its clipped length, one pixel per cycle
// a query runs the divider (7 steps and a done check), setup, then per sample the
// bounds, index multiply, memory read and test steps for up to (major >> 2) + 1 samples,
// then the result state
// a finished result sits in the output register while new items are accepted;
// a query whose result finds that register still full waits until it drains
// asynchronous reset clears the page flags and fill counts; memory is not cleared
`default_nettype none
module mask_line_of_sight_tester_core
	import mlos_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // run_length, run_value, target_x, target_y, start_x, start_y
	input  wire logic [IN_USER_W-1:0]  s_tuser,  // op, page
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata   // line_blocked
);
	cmd_t    cmd;
	status_t status;

	assign s_tready = cmd.in_ready;

	mlos_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (s_tvalid && cmd.in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	mlos_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);
endmodule
`default_nettype wire
